@@ sv/hrbe_pkg.sv @@
package hrbe_pkg;

  localparam int unsigned PREFIX_LEN    = 15;
  localparam int unsigned PREFIX_ENDED  = 16;
  localparam int unsigned MATCH_W       = 5;
  localparam int unsigned RUN_W         = 3;
  localparam int unsigned VALUE_W       = 32;

  localparam logic [RUN_W-1:0] BREAK_RUN_END = 3'd4;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5a;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_in;
  } beat_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       body_last;
    logic [1:0] phase;
    logic       length_seen;
  } result_t;

  // "content-length:" in lower case
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h63;
      4'd1:    ch = 8'h6f;
      4'd2:    ch = 8'h6e;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6e;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2d;
      4'd8:    ch = 8'h6c;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6e;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      4'd14:   ch = 8'h3a;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

endpackage

@@ sv/hrbe_core.sv @@
module hrbe_core
  import hrbe_pkg::*;
#(
  parameter int unsigned LINE_CHARS = 128
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    beat_valid,
  input  beat_t   beat,
  output result_t result
);

  localparam int unsigned LC_W = $clog2(LINE_CHARS + 1);
  localparam logic [LC_W-1:0] LC_MAX = LC_W'(LINE_CHARS);

  phase_t               phase, phase_next;
  logic [RUN_W-1:0]     line_break_run, line_break_run_next;
  logic [LC_W-1:0]      line_chars, line_chars_next;
  logic [MATCH_W-1:0]   prefix_matched, prefix_matched_next;
  logic                 prefix_failed, prefix_failed_next;
  logic [VALUE_W-1:0]   line_value, line_value_next;
  logic [VALUE_W-1:0]   remaining_length, remaining_length_next;
  logic                 length_flag, length_flag_next;

  logic                 is_restart;
  logic                 is_break;
  logic [RUN_W-1:0]     run_inc;
  logic                 run_end;
  logic [VALUE_W-1:0]   rem_dec;
  logic                 rem_zero;
  logic                 line_ok;
  logic                 is_digit;
  logic [7:0]           digit;

  assign is_restart = (beat.req_type == REQ_RESTART);
  assign is_break   = (beat.byte_in == CHAR_CR) || (beat.byte_in == CHAR_LF);
  assign run_inc    = line_break_run + RUN_W'(1);
  assign run_end    = (run_inc >= BREAK_RUN_END);
  assign rem_dec    = (remaining_length != '0) ? remaining_length - VALUE_W'(1)
                                               : remaining_length;
  assign rem_zero   = (rem_dec == '0);
  assign line_ok    = (line_chars != '0) && !prefix_failed &&
                      (prefix_matched >= MATCH_W'(PREFIX_LEN)) &&
                      (line_chars < LC_MAX);
  assign is_digit   = (beat.byte_in >= CHAR_0) && (beat.byte_in <= CHAR_9);
  assign digit      = beat.byte_in - CHAR_0;

  // phase sequencing
  always_comb begin
    phase_next = phase;
    if (beat_valid) begin
      if (is_restart) begin
        phase_next = PH_HEADER;
      end else begin
        unique case (phase)
          PH_HEADER: if (is_break && run_end) phase_next = PH_BODY;
          PH_BODY:   if (rem_zero) phase_next = PH_DONE;
          PH_DONE:   phase_next = PH_DONE;
          default:   phase_next = PH_HEADER;
        endcase
      end
    end
  end

  // line parser and length counter
  always_comb begin
    line_break_run_next   = line_break_run;
    line_chars_next       = line_chars;
    prefix_matched_next   = prefix_matched;
    prefix_failed_next    = prefix_failed;
    line_value_next       = line_value;
    remaining_length_next = remaining_length;
    length_flag_next      = length_flag;
    if (beat_valid) begin
      if (is_restart) begin
        line_break_run_next   = '0;
        line_chars_next       = '0;
        prefix_matched_next   = '0;
        prefix_failed_next    = 1'b0;
        line_value_next       = '0;
        remaining_length_next = '0;
        length_flag_next      = 1'b0;
      end else if (phase == PH_HEADER) begin
        if (is_break) begin
          if (run_end) begin
            line_break_run_next = BREAK_RUN_END;
          end else begin
            line_break_run_next = run_inc;
            if (line_ok) begin
              remaining_length_next = line_value;
              length_flag_next      = 1'b1;
            end
            line_chars_next     = '0;
            prefix_matched_next = '0;
            prefix_failed_next  = 1'b0;
            line_value_next     = '0;
          end
        end else begin
          line_break_run_next = '0;
          if (line_chars < LC_MAX) begin
            line_chars_next = line_chars + LC_W'(1);
          end
          if (!prefix_failed) begin
            if (prefix_matched < MATCH_W'(PREFIX_LEN)) begin
              if (fold_case(beat.byte_in) == prefix_char(prefix_matched[3:0])) begin
                prefix_matched_next = prefix_matched + MATCH_W'(1);
              end else begin
                prefix_failed_next = 1'b1;
              end
            end else if (prefix_matched == MATCH_W'(PREFIX_LEN)) begin
              if (beat.byte_in == CHAR_NUL) begin
                prefix_matched_next = MATCH_W'(PREFIX_ENDED);
              end else if (is_digit) begin
                line_value_next = (line_value << 3) + (line_value << 1) +
                                  {{(VALUE_W-8){1'b0}}, digit};
              end
            end
          end
        end
      end else if (phase == PH_BODY) begin
        remaining_length_next = rem_dec;
      end
    end
  end

  // result
  always_comb begin
    result.body_valid  = !is_restart && (phase == PH_BODY);
    result.body_byte   = result.body_valid ? beat.byte_in : 8'h00;
    result.body_last   = result.body_valid && rem_zero;
    result.phase       = phase_next;
    result.length_seen = length_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      line_break_run   <= '0;
      line_chars       <= '0;
      prefix_matched   <= '0;
      prefix_failed    <= 1'b0;
      line_value       <= '0;
      remaining_length <= '0;
      length_flag      <= 1'b0;
    end else begin
      phase            <= phase_next;
      line_break_run   <= line_break_run_next;
      line_chars       <= line_chars_next;
      prefix_matched   <= prefix_matched_next;
      prefix_failed    <= prefix_failed_next;
      line_value       <= line_value_next;
      remaining_length <= remaining_length_next;
      length_flag      <= length_flag_next;
    end
  end

endmodule

@@ sv/http_response_body_extractor_unit.sv @@
// channel  | handshake                  | beat fields
// item     | item_valid / item_stall    | req_type, byte_in
// result   | result_valid / result_stall| body_valid, body_byte, body_last, phase, length_seen
//
// One beat per cycle while result_stall is low; the path is an input register, then
// parser state update and result register in the same cycle.
// Parser state advances only as a beat moves from the input register to the result.
// rst is synchronous: clears both stage valids and all parser state.
// result_stall holds both stages; item_stall rises only when both are full.
module http_response_body_extractor_unit
  import hrbe_pkg::*;
#(
  parameter int unsigned LINE_CHARS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       req_type,
  input  logic [7:0] byte_in,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       body_valid,
  output logic [7:0] body_byte,
  output logic       body_last,
  output logic [1:0] phase,
  output logic       length_seen
);

  logic    in_full;
  beat_t   in_beat;
  logic    out_open;
  logic    advance;
  result_t core_result;
  result_t res;

  assign out_open   = !result_valid || !result_stall;
  assign advance    = in_full && out_open;
  assign item_stall = in_full && !out_open;

  hrbe_core #(
    .LINE_CHARS(LINE_CHARS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .beat_valid(advance),
    .beat      (in_beat),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!item_stall) begin
        in_full <= item_valid;
      end
      if (out_open) begin
        result_valid <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_beat.req_type <= req_type;
      in_beat.byte_in  <= byte_in;
    end
    if (advance) begin
      res <= core_result;
    end
  end

  assign body_valid  = res.body_valid;
  assign body_byte   = res.body_byte;
  assign body_last   = res.body_last;
  assign phase       = res.phase;
  assign length_seen = res.length_seen;

endmodule

@@ sv/hrbe_check.sv @@
module hrbe_check
  import hrbe_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic       body_valid,
  input logic [7:0] body_byte,
  input logic       body_last,
  input logic [1:0] phase,
  input logic       length_seen
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(body_byte) &&
      $stable(body_valid) && $stable(body_last) && $stable(phase) &&
      $stable(length_seen))
    else $error("result beat changed while stalled");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && body_last |-> body_valid && (phase == PH_DONE))
    else $error("last body beat without done phase");

  a_idle_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && !body_valid |-> (body_byte == 8'h00) && !body_last)
    else $error("payload on a non-body beat");

  a_body_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && body_valid && !body_last |-> (phase == PH_BODY))
    else $error("body beat outside body phase");

endmodule

bind http_response_body_extractor_unit hrbe_check u_hrbe_check (.*);
